FILE: hdl/fbwf_pkg.sv
// Types and constants of the flash block word framer.
// Shared by every module in hdl/ but fbwf_fifo; depends on nothing else.
package fbwf_pkg;

  // One input item: byte of a flash write, with the write's header fields.
  typedef struct packed {
    logic        action;
    logic [31:0] start_offset;
    logic [31:0] total_count;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_OFFSET = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_CHECK  = 2'd3
  } word_kind_e;

  typedef struct packed {
    logic [31:0] out_word;
    word_kind_e  word_kind;
    logic        end_of_block;
    logic        config_error;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_BUF_LEN   = 2'd0,
    REG_BUF_ALIGN = 2'd1,
    REG_BLOCK_CMD = 2'd2,
    REG_CSUM_SEED = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] buffer_length;
    logic [15:0] buffer_alignment;
    logic [31:0] block_command;
    logic [31:0] checksum_seed;
  } cfg_t;

  // Class the front end attaches to each queued request.
  typedef enum logic [1:0] {
    CLS_CONT  = 2'd0,
    CLS_START = 2'd1,
    CLS_EMPTY = 2'd2
  } item_class_e;

  typedef struct packed {
    item_class_e cls;
    in_item_t    item;
  } q_item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_CHECK,
    S_DIV,
    S_HDR,
    S_OFS,
    S_BYTE,
    S_DATA,
    S_TAIL,
    S_CHK,
    S_ERR
  } back_state_e;

  localparam logic [31:0] WORD_ONES  = 32'hffffffff;
  localparam logic [31:0] LANE0_KEEP = 32'hffffff00;
  localparam logic [31:0] LANE1_KEEP = 32'hffff00ff;
  localparam logic [31:0] LANE2_KEEP = 32'hff00ffff;
  localparam logic [31:0] LANE3_KEEP = 32'h00ffffff;

  // Write one byte into its lane of a word whose free lanes hold 0xFF.
  function automatic logic [31:0] merge_byte(input logic [31:0] acc, input logic [1:0] lane,
                                             input logic [7:0] b);
    logic [31:0] res;
    case (lane)
      2'd0:    res = acc & (LANE0_KEEP | {24'h0, b});
      2'd1:    res = acc & (LANE1_KEEP | {16'h0, b, 8'h0});
      2'd2:    res = acc & (LANE2_KEEP | {8'h0, b, 16'h0});
      2'd3:    res = acc & (LANE3_KEEP | {b, 24'h0});
      default: res = acc;
    endcase
    return res;
  endfunction

endpackage

FILE: hdl/fbwf_fifo.sv
// Small first-in first-out queue of Width-bit entries.
// Generic; uses no package.
module fbwf_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/fbwf_front.sv
// Front end: classifies incoming requests and queues them for the sequencer.
// Depends on fbwf_pkg and fbwf_fifo.
module fbwf_front #(
  parameter int Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fbwf_pkg::in_item_t item_i,
  output logic               full_o,
  output logic               q_valid_o,
  output fbwf_pkg::q_item_t  q_item_o,
  input  logic               q_pop_i
);
  import fbwf_pkg::*;

  q_item_t tagged_item;
  logic    q_empty;

  // Tag a new write with an empty count apart from other new writes.
  always_comb begin
    tagged_item.item = item_i;
    if (!item_i.action) begin
      tagged_item.cls = CLS_CONT;
    end else if (item_i.total_count == 32'd0) begin
      tagged_item.cls = CLS_EMPTY;
    end else begin
      tagged_item.cls = CLS_START;
    end
  end

  fbwf_fifo #(
    .Width ($bits(q_item_t)),
    .Depth (Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (tagged_item),
    .full_o  (full_o),
    .pop_i   (q_pop_i),
    .data_o  (q_item_o),
    .empty_o (q_empty)
  );

  assign q_valid_o = !q_empty;

endmodule

FILE: hdl/fbwf_div.sv
// Iterative remainder unit: 32-bit dividend modulo 16-bit divisor, one bit a cycle.
// Depends on fbwf_pkg.
module fbwf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbwf_pkg::div_req_t req_i,
  output fbwf_pkg::div_rsp_t rsp_o
);
  import fbwf_pkg::*;

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] dvd_q, dvd_d;
  logic [15:0] dsr_q, dsr_d, rem_q, rem_d;
  logic [16:0] trial, diff;

  assign trial = {rem_q, dvd_q[31]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      // Restoring step: keep the difference when it does not go negative.
      rem_d = (trial >= {1'b0, dsr_q}) ? diff[15:0] : trial[15:0];
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: hdl/fbwf_back.sv
// Back end: sequencer that cuts writes into runs and emits the frame words.
// Depends on fbwf_pkg; drives the remainder unit and the result queue.
module fbwf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fbwf_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  fbwf_pkg::q_item_t   q_item_i,
  output logic                q_pop_o,
  output fbwf_pkg::div_req_t  div_req_o,
  input  fbwf_pkg::div_rsp_t  div_rsp_i,
  output logic                out_push_o,
  output fbwf_pkg::out_item_t out_item_o,
  input  logic                out_full_i
);
  import fbwf_pkg::*;

  back_state_e state_q, state_d;
  q_item_t     it_q, it_d;
  logic [31:0] bytes_rem_q, bytes_rem_d, cur_off_q, cur_off_d;
  logic [15:0] run_left_q, run_left_d;
  logic [1:0]  lane_q, lane_d;
  logic [31:0] acc_q, acc_d, csum_q, csum_d;

  logic        cfg_bad;
  logic [32:0] run_span;
  logic [15:0] run_len;
  logic        emit;

  assign cfg_bad = (cfg_i.buffer_length == 16'd0) || (cfg_i.buffer_alignment == 16'd0);

  // Run length from the alignment remainder; clamp when the remainder eats the buffer.
  always_comb begin
    run_span = {1'b0, bytes_rem_q} + {17'd0, div_rsp_i.rem};
    if (run_span > {17'd0, cfg_i.buffer_length}) begin
      if (div_rsp_i.rem < cfg_i.buffer_length) begin
        run_len = cfg_i.buffer_length - div_rsp_i.rem;
      end else if (bytes_rem_q < {16'd0, cfg_i.buffer_length}) begin
        run_len = bytes_rem_q[15:0];
      end else begin
        run_len = cfg_i.buffer_length;
      end
    end else begin
      run_len = bytes_rem_q[15:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) state_d = S_START;
      end
      S_START: begin
        if (it_q.cls == CLS_CONT) begin
          state_d = S_CHECK;
        end else begin
          state_d = cfg_bad ? S_ERR : S_CHECK;
        end
      end
      S_CHECK: begin
        if (bytes_rem_q == 32'd0) begin
          state_d = S_IDLE;
        end else if (run_left_q == 16'd0) begin
          state_d = cfg_bad ? S_ERR : S_DIV;
        end else begin
          state_d = S_BYTE;
        end
      end
      S_DIV: begin
        if (div_rsp_i.done) state_d = S_HDR;
      end
      S_HDR: begin
        if (!out_full_i) state_d = S_OFS;
      end
      S_OFS: begin
        if (!out_full_i) state_d = S_BYTE;
      end
      S_BYTE: begin
        if (lane_q == 2'd3) begin
          state_d = S_DATA;
        end else if (run_left_q == 16'd1) begin
          state_d = S_TAIL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DATA: begin
        if (!out_full_i) state_d = (run_left_q == 16'd0) ? S_CHK : S_IDLE;
      end
      S_TAIL: begin
        if (!out_full_i) state_d = S_CHK;
      end
      S_CHK, S_ERR: begin
        if (!out_full_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    it_d        = it_q;
    bytes_rem_d = bytes_rem_q;
    cur_off_d   = cur_off_q;
    run_left_d  = run_left_q;
    lane_d      = lane_q;
    acc_d       = acc_q;
    csum_d      = csum_q;
    q_pop_o     = 1'b0;
    div_req_o   = '{start: 1'b0, dividend: cur_off_q, divisor: cfg_i.buffer_alignment};
    emit        = 1'b0;
    out_item_o  = '{out_word: 32'd0, word_kind: KIND_HEADER, end_of_block: 1'b0,
                    config_error: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          it_d    = q_item_i;
          q_pop_o = 1'b1;
        end
      end
      S_START: begin
        if (it_q.cls != CLS_CONT) begin
          run_left_d = '0;
          if (cfg_bad) begin
            bytes_rem_d = '0;
          end else begin
            bytes_rem_d = it_q.item.total_count;
            cur_off_d   = it_q.item.start_offset;
          end
        end
      end
      S_CHECK: begin
        if (bytes_rem_q != 32'd0 && run_left_q == 16'd0) begin
          if (cfg_bad) begin
            bytes_rem_d = '0;
          end else begin
            div_req_o.start = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_rsp_i.done) begin
          run_left_d = run_len;
          lane_d     = div_rsp_i.rem[1:0];
          acc_d      = WORD_ONES;
          csum_d     = cfg_i.checksum_seed;
        end
      end
      S_HDR: begin
        emit                = 1'b1;
        out_item_o.out_word = cfg_i.block_command | {16'd0, run_left_q};
      end
      S_OFS: begin
        emit                 = 1'b1;
        out_item_o.out_word  = cur_off_q;
        out_item_o.word_kind = KIND_OFFSET;
      end
      S_BYTE: begin
        acc_d       = merge_byte(acc_q, lane_q, it_q.item.data_byte);
        run_left_d  = run_left_q - 16'd1;
        bytes_rem_d = bytes_rem_q - 32'd1;
        cur_off_d   = cur_off_q + 32'd1;
        if (lane_q != 2'd3) lane_d = lane_q + 2'd1;
      end
      S_DATA: begin
        emit                 = 1'b1;
        out_item_o.out_word  = acc_q;
        out_item_o.word_kind = KIND_DATA;
        if (!out_full_i) begin
          csum_d = csum_q ^ acc_q;
          acc_d  = WORD_ONES;
          lane_d = 2'd0;
        end
      end
      S_TAIL: begin
        emit                 = 1'b1;
        out_item_o.out_word  = acc_q;
        out_item_o.word_kind = KIND_DATA;
        if (!out_full_i) csum_d = csum_q ^ acc_q;
      end
      S_CHK: begin
        emit                    = 1'b1;
        out_item_o.out_word     = csum_q;
        out_item_o.word_kind    = KIND_CHECK;
        out_item_o.end_of_block = 1'b1;
        if (!out_full_i) begin
          acc_d  = WORD_ONES;
          lane_d = 2'd0;
        end
      end
      S_ERR: begin
        emit                    = 1'b1;
        out_item_o.config_error = 1'b1;
      end
      default: ;
    endcase
    out_push_o = emit && !out_full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bytes_rem_q <= '0;
      cur_off_q   <= '0;
      run_left_q  <= '0;
      lane_q      <= '0;
      acc_q       <= WORD_ONES;
      csum_q      <= '0;
    end else begin
      state_q     <= state_d;
      bytes_rem_q <= bytes_rem_d;
      cur_off_q   <= cur_off_d;
      run_left_q  <= run_left_d;
      lane_q      <= lane_d;
      acc_q       <= acc_d;
      csum_q      <= csum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d;
  end

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_o.start |-> !div_rsp_i.busy)
    else $error("remainder unit restarted while busy");

  a_byte_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BYTE) |-> (run_left_q != 16'd0))
    else $error("byte placed outside a run");

  a_lane_clear_after_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK && !out_full_i) |=> (lane_q == 2'd0 && acc_q == WORD_ONES))
    else $error("word packer not cleared after checksum");

  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (q_valid_i && state_q == S_IDLE))
    else $error("request taken from empty queue");
`endif

endmodule

FILE: hdl/flash_block_word_framer.sv
// Flash block word framer: turns a byte stream of a flash write into framed runs
// (header, offset, packed data words, checksum). Requests enter through a queue
// and are handled one at a time by a sequencer. A byte that continues a run is
// placed into its lane of a data word, which goes out when full or at run end; a
// byte that opens a run first waits for the remainder unit (offset modulo
// alignment, one bit a cycle), then the header and offset words are emitted.
// Results wait in a queue of OutDepth entries.
// Depends on fbwf_pkg, fbwf_front, fbwf_div, fbwf_back and fbwf_fifo.
module flash_block_word_framer #(
  parameter int InDepth  = 2,
  parameter int OutDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  fbwf_pkg::in_item_t  in_data_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output fbwf_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i
);
  import fbwf_pkg::*;

  cfg_t      cfg_q, cfg_d;
  logic      q_valid, q_pop;
  q_item_t   q_item;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  logic      out_push, out_full;
  out_item_t out_item;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BUF_LEN:   cfg_d.buffer_length    = cfg_wdata_i[15:0];
        REG_BUF_ALIGN: cfg_d.buffer_alignment = cfg_wdata_i[15:0];
        REG_BLOCK_CMD: cfg_d.block_command    = cfg_wdata_i;
        REG_CSUM_SEED: cfg_d.checksum_seed    = cfg_wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{buffer_length: 16'd0, buffer_alignment: 16'd1, block_command: 32'd0,
                 checksum_seed: 32'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fbwf_front #(
    .Depth (InDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .item_i    (in_data_i),
    .full_o    (full),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  fbwf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  fbwf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .out_push_o (out_push),
    .out_item_o (out_item),
    .out_full_i (out_full)
  );

  fbwf_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (OutDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_item),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

endmodule
